// ----- rtl/mvsm_pkg.sv -----
// Shared constants, types and codes of the multi-voice sample mixer.
package mvsm_pkg;

	// Voice bank size and position counter width
	localparam int VOICES        = 8;
	localparam int POSITION_BITS = 24;
	localparam int VIDX_W        = (VOICES > 1) ? $clog2(VOICES) : 1;

	// Fixed field widths
	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 16;
	localparam int LEN_W      = 24;
	localparam int MASK_W     = 8;
	localparam int COUNT_W    = 4;
	localparam int ASSIGN_W   = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Arithmetic widths: sample times gain, scaled term, voice sum
	localparam int FRAC_BITS = 15;
	localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
	localparam int TERM_W    = SAMPLE_W + 1;
	localparam int SUM_W     = TERM_W + $clog2(VOICES + 1) + 1;

	// Register reset values
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'h8000;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_EN = 1'b1;

	// Input item actions
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_MIX   = 1'b1;

	// Types
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [POSITION_BITS-1:0]   pos_t;
	typedef logic [VOICES-1:0]          vmask_t;
	typedef logic [VIDX_W-1:0]          vidx_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [TERM_W-1:0]   term_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic [COUNT_W-1:0]         count_t;

	// Term and output limits and truncation bias toward zero
	localparam prod_t TERM_MAX  = prod_t'(32768);
	localparam prod_t TERM_MIN  = -prod_t'(32768);
	localparam prod_t TRUNC_BIAS = prod_t'((1 << FRAC_BITS) - 1);
	localparam sum_t  OUT_MAX   = sum_t'(32767);
	localparam sum_t  OUT_MIN   = -sum_t'(32768);

	// Mask with every existing voice set
	localparam logic [MASK_W-1:0] FULL_MASK = MASK_W'((1 << VOICES) - 1);

	// Voice bank status for the item in the first stage
	typedef struct packed {
		vmask_t sound;    // voices that add their sample this frame
		vmask_t mask;     // voices active after this item
		vidx_t  assigned; // voice claimed by a start
		logic   full;     // start found no free voice
	} voice_stat_t;

endpackage

// ----- rtl/multi_voice_sample_mixer.sv -----
// Top level of the multi-voice sample mixer: input stage, gain multiply, sum and output.
//
// Usage: items enter on the in_* channel (valid/stall). A start item (action 0)
// claims the lowest free voice with sound_length samples, or reports start_full.
// A mix item (action 1) brings one sample per voice; every playing voice either
// ends (position reached its length, no sound) or adds sample * gain_q15 / 32768,
// truncated toward zero, and advances. The saturated sum shows on mix_left and
// mix_right, or zero while output_enable is low.
// Each item passes the input register, product register and result register before
// out_valid rises. Throughput: one transaction per cycle unless the receiver stalls; the
// voice state is read and updated in the first stage, so items may follow back to back.
// The eight 16x17 multipliers feed a register, the scaling, clamping and adder
// tree sit before the result register.
// Reset clears all voices, sets gain to unity and enables output.
// When the receiver stalls, the result holds and the stages behind it fill; in_stall
// rises only once every stage holds a transaction. The user writes configuration (gain
// index 0, output enable index 1) only while idle; the block does not enforce it.
module multi_voice_sample_mixer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port
	input  logic                                 cfg_write,
	input  logic [mvsm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mvsm_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 action,
	input  logic [mvsm_pkg::LEN_W-1:0]           sound_length,
	input  logic signed [mvsm_pkg::SAMPLE_W-1:0] voice_sample_0,
	input  logic signed [mvsm_pkg::SAMPLE_W-1:0] voice_sample_1,
	input  logic signed [mvsm_pkg::SAMPLE_W-1:0] voice_sample_2,
	input  logic signed [mvsm_pkg::SAMPLE_W-1:0] voice_sample_3,
	input  logic signed [mvsm_pkg::SAMPLE_W-1:0] voice_sample_4,
	input  logic signed [mvsm_pkg::SAMPLE_W-1:0] voice_sample_5,
	input  logic signed [mvsm_pkg::SAMPLE_W-1:0] voice_sample_6,
	input  logic signed [mvsm_pkg::SAMPLE_W-1:0] voice_sample_7,
	// Output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [mvsm_pkg::SAMPLE_W-1:0] mix_left,
	output logic signed [mvsm_pkg::SAMPLE_W-1:0] mix_right,
	output logic [mvsm_pkg::ASSIGN_W-1:0]        assigned_voice,
	output logic                                 start_full,
	output logic [mvsm_pkg::MASK_W-1:0]          active_mask,
	output logic [mvsm_pkg::COUNT_W-1:0]         active_count
);

	// Configuration registers
	logic [mvsm_pkg::GAIN_W-1:0] gain_q;
	logic                        out_en_q;

	// Stage 1: captured input item
	logic                  s1_v;
	logic                  s1_action;
	logic [mvsm_pkg::LEN_W-1:0] s1_len;
	mvsm_pkg::sample_t     s1_samp [mvsm_pkg::VOICES];

	// Stage 2: gated products and status
	logic                  s2_v;
	mvsm_pkg::prod_t       s2_prod [mvsm_pkg::VOICES];
	mvsm_pkg::vmask_t      s2_mask;
	mvsm_pkg::vidx_t       s2_assigned;
	logic                  s2_full;

	// Result register
	logic                  out_valid_q;
	mvsm_pkg::sample_t     mix_q;
	logic [mvsm_pkg::ASSIGN_W-1:0] assigned_q;
	logic                  full_q;
	logic [mvsm_pkg::MASK_W-1:0]   mask_q;
	mvsm_pkg::count_t      count_q;

	// Handshake and datapath nets
	mvsm_pkg::sample_t     in_samp [mvsm_pkg::VOICES];
	mvsm_pkg::voice_stat_t stat;
	logic                  in_take;
	logic                  s1_go;
	logic                  s2_rdy;
	logic                  s2_go;
	logic                  out_rdy;
	logic signed [mvsm_pkg::GAIN_W:0] gain_s;
	mvsm_pkg::sample_t     samp_g [mvsm_pkg::VOICES];
	mvsm_pkg::sample_t     mix_d;
	mvsm_pkg::count_t      count_d;
	mvsm_pkg::sum_t        acc;

	// Scale one product by 2^-15 toward zero and clamp to +-32768
	function automatic mvsm_pkg::term_t scale_term(input mvsm_pkg::prod_t p);
		mvsm_pkg::prod_t b;
		mvsm_pkg::prod_t q;
		b = p[mvsm_pkg::PROD_W-1] ? (p + mvsm_pkg::TRUNC_BIAS) : p;
		q = b >>> mvsm_pkg::FRAC_BITS;
		if (q > mvsm_pkg::TERM_MAX) begin
			q = mvsm_pkg::TERM_MAX;
		end else if (q < mvsm_pkg::TERM_MIN) begin
			q = mvsm_pkg::TERM_MIN;
		end
		return mvsm_pkg::term_t'(q);
	endfunction

	// Gather per-voice sample ports
	always_comb begin
		in_samp[0] = voice_sample_0;
		if (mvsm_pkg::VOICES > 1) in_samp[1 % mvsm_pkg::VOICES] = voice_sample_1;
		if (mvsm_pkg::VOICES > 2) in_samp[2 % mvsm_pkg::VOICES] = voice_sample_2;
		if (mvsm_pkg::VOICES > 3) in_samp[3 % mvsm_pkg::VOICES] = voice_sample_3;
		if (mvsm_pkg::VOICES > 4) in_samp[4 % mvsm_pkg::VOICES] = voice_sample_4;
		if (mvsm_pkg::VOICES > 5) in_samp[5 % mvsm_pkg::VOICES] = voice_sample_5;
		if (mvsm_pkg::VOICES > 6) in_samp[6 % mvsm_pkg::VOICES] = voice_sample_6;
		if (mvsm_pkg::VOICES > 7) in_samp[7 % mvsm_pkg::VOICES] = voice_sample_7;
	end

	// Flow control: each stage moves when the one ahead has room
	assign out_rdy  = !out_valid_q || !out_stall;
	assign s2_go    = s2_v && out_rdy;
	assign s2_rdy   = !s2_v || out_rdy;
	assign s1_go    = s1_v && s2_rdy;
	assign in_stall = s1_v && !s2_rdy;
	assign in_take  = in_valid && !in_stall;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= mvsm_pkg::GAIN_RESET;
			out_en_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mvsm_pkg::CFG_GAIN:   gain_q   <= cfg_data;
				mvsm_pkg::CFG_OUT_EN: out_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (in_take) begin
			s1_v <= 1'b1;
		end else if (s1_go) begin
			s1_v <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			s1_action <= action;
			s1_len    <= sound_length;
			for (int v = 0; v < mvsm_pkg::VOICES; v++) begin
				s1_samp[v] <= in_samp[v];
			end
		end
	end

	// Voice state lives with stage 1
	mvsm_voice_bank u_voice_bank (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (s1_go),
		.action       (s1_action),
		.sound_length (s1_len),
		.stat         (stat)
	);

	// Silence voices that do not sound, then multiply by gain
	assign gain_s = $signed({1'b0, gain_q});

	always_comb begin
		for (int v = 0; v < mvsm_pkg::VOICES; v++) begin
			samp_g[v] = stat.sound[v] ? s1_samp[v] : '0;
		end
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (s1_go) begin
			s2_v <= 1'b1;
		end else if (s2_go) begin
			s2_v <= 1'b0;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (s1_go) begin
			for (int v = 0; v < mvsm_pkg::VOICES; v++) begin
				s2_prod[v] <= samp_g[v] * gain_s;
			end
			s2_mask     <= stat.mask;
			s2_assigned <= stat.assigned;
			s2_full     <= stat.full;
		end
	end

	// Scale, clamp, sum and saturate the frame
	always_comb begin
		acc = '0;
		for (int v = 0; v < mvsm_pkg::VOICES; v++) begin
			acc = acc + mvsm_pkg::sum_t'(scale_term(s2_prod[v]));
		end
		if (!out_en_q) begin
			mix_d = '0;
		end else if (acc > mvsm_pkg::OUT_MAX) begin
			mix_d = mvsm_pkg::sample_t'(mvsm_pkg::OUT_MAX);
		end else if (acc < mvsm_pkg::OUT_MIN) begin
			mix_d = mvsm_pkg::sample_t'(mvsm_pkg::OUT_MIN);
		end else begin
			mix_d = mvsm_pkg::sample_t'(acc);
		end
	end

	// Count playing voices
	always_comb begin
		count_d = '0;
		for (int v = 0; v < mvsm_pkg::VOICES; v++) begin
			count_d = count_d + mvsm_pkg::count_t'(s2_mask[v]);
		end
	end

	// Result control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go) begin
			out_valid_q <= 1'b1;
		end else if (out_rdy) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (s2_go) begin
			mix_q      <= mix_d;
			assigned_q <= mvsm_pkg::ASSIGN_W'(s2_assigned);
			full_q     <= s2_full;
			mask_q     <= mvsm_pkg::MASK_W'(s2_mask);
			count_q    <= count_d;
		end
	end

	// Drive outputs
	assign out_valid      = out_valid_q;
	assign mix_left       = mix_q;
	assign mix_right      = mix_q;
	assign assigned_voice = assigned_q;
	assign start_full     = full_q;
	assign active_mask    = mask_q;
	assign active_count   = count_q;

endmodule

// ----- rtl/mvsm_voice_bank.sv -----
// Voice state: allocation, position tracking and end-of-sound release.
module mvsm_voice_bank (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  step,
	input  logic                                  action,
	input  logic [mvsm_pkg::LEN_W-1:0]            sound_length,
	output mvsm_pkg::voice_stat_t                 stat
);

	logic                  act_q [mvsm_pkg::VOICES];
	mvsm_pkg::pos_t        pos_q [mvsm_pkg::VOICES];
	mvsm_pkg::pos_t        len_q [mvsm_pkg::VOICES];
	mvsm_pkg::vmask_t      act_vec;
	mvsm_pkg::vmask_t      ends;
	mvsm_pkg::vmask_t      sound;
	mvsm_pkg::vidx_t       sel;
	logic                  found;

	// Classify each voice for a mix frame
	always_comb begin
		for (int v = 0; v < mvsm_pkg::VOICES; v++) begin
			act_vec[v] = act_q[v];
			ends[v]    = act_q[v] && (pos_q[v] >= len_q[v]);
			sound[v]   = act_q[v] && !(pos_q[v] >= len_q[v]);
		end
	end

	// Find the lowest free voice
	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int v = mvsm_pkg::VOICES - 1; v >= 0; v--) begin
			if (!act_q[v]) begin
				found = 1'b1;
				sel   = mvsm_pkg::vidx_t'(v);
			end
		end
	end

	// Report status after this item
	always_comb begin
		if (action == mvsm_pkg::ACT_START) begin
			stat.sound    = '0;
			stat.mask     = act_vec | (found ? (mvsm_pkg::vmask_t'(1) << sel) : '0);
			stat.assigned = found ? sel : '0;
			stat.full     = !found;
		end else begin
			stat.sound    = sound;
			stat.mask     = act_vec & ~ends;
			stat.assigned = '0;
			stat.full     = 1'b0;
		end
	end

	// Claim, advance and release voices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < mvsm_pkg::VOICES; v++) begin
				act_q[v] <= 1'b0;
				pos_q[v] <= '0;
				len_q[v] <= '0;
			end
		end else if (step) begin
			if (action == mvsm_pkg::ACT_START) begin
				if (found) begin
					act_q[sel] <= 1'b1;
					pos_q[sel] <= '0;
					len_q[sel] <= mvsm_pkg::pos_t'(sound_length);
				end
			end else begin
				for (int v = 0; v < mvsm_pkg::VOICES; v++) begin
					if (ends[v]) begin
						act_q[v] <= 1'b0;
					end
					if (sound[v]) begin
						pos_q[v] <= pos_q[v] + mvsm_pkg::pos_t'(1);
					end
				end
			end
		end
	end

endmodule

// ----- rtl/mvsm_checker.sv -----
// Port-level checks of the multi-voice sample mixer, bound to the top level.
module mvsm_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [mvsm_pkg::SAMPLE_W-1:0] mix_left,
	input  logic signed [mvsm_pkg::SAMPLE_W-1:0] mix_right,
	input  logic [mvsm_pkg::ASSIGN_W-1:0]        assigned_voice,
	input  logic                                 start_full,
	input  logic [mvsm_pkg::MASK_W-1:0]          active_mask,
	input  logic [mvsm_pkg::COUNT_W-1:0]         active_count
);

	// Hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mix_left) && $stable(active_mask))
		else $error("stalled result changed");

	// Both channels carry the same sample
	a_stereo_equal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mix_left == mix_right)
		else $error("left and right differ");

	// Count matches the mask
	a_count_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> active_count == mvsm_pkg::COUNT_W'($countones(active_mask)))
		else $error("active count disagrees with mask");

	// A full start means every voice plays, with no voice and no sound reported
	a_full_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_full |->
			active_mask == mvsm_pkg::FULL_MASK && assigned_voice == '0 && mix_left == '0)
		else $error("full start with inconsistent status");

	// A claimed voice is playing
	a_assigned_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && assigned_voice != '0 |-> active_mask[assigned_voice] && mix_left == '0)
		else $error("assigned voice not active");

endmodule

bind multi_voice_sample_mixer mvsm_checker u_mvsm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.mix_left       (mix_left),
	.mix_right      (mix_right),
	.assigned_voice (assigned_voice),
	.start_full     (start_full),
	.active_mask    (active_mask),
	.active_count   (active_count)
);
